[hdl/bdm_pkg.sv]
// Shared types, register indexes, colour order codes and defaults for the Bayer demosaic.
`default_nettype none

package bdm_pkg;

    // Fixed field widths.
    localparam int CHANNEL_BITS   = 16;
    localparam int COORD_BITS     = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CHANNEL_BITS-1:0]   channel_t;
    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_BAYER_PATTERN = 2'd0;
    localparam cfg_index_t CFG_IMAGE_WIDTH   = 2'd1;
    localparam cfg_index_t CFG_IMAGE_HEIGHT  = 2'd2;

    // Colour order at the top-left corner of the frame.
    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GRBG = 2'd2;
    localparam logic [1:0] PAT_GBRG = 2'd3;

    // Frame size limits and reset values.
    localparam int MIN_SIZE         = 4;
    localparam int MAX_HEIGHT       = 4096;
    localparam int RESET_WIDTH      = 4096;
    localparam int RESET_HEIGHT     = 4096;

    // Defaults of the top-level parameters.
    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int PIXEL_BITS_DEFAULT = 16;

endpackage

`default_nettype wire

[hdl/bdm_pixel_if.sv]
// Stream interface that carries raw Bayer samples.
`default_nettype none

interface bdm_pixel_if;

    logic              valid;
    logic              ready;
    bdm_pkg::channel_t raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);

endinterface

`default_nettype wire

[hdl/bdm_rgb_if.sv]
// Stream interface that carries demosaiced RGB pixels with their coordinates.
`default_nettype none

interface bdm_rgb_if;

    logic              valid;
    logic              ready;
    bdm_pkg::channel_t red;
    bdm_pkg::channel_t green;
    bdm_pkg::channel_t blue;
    bdm_pkg::coord_t   out_column;
    bdm_pkg::coord_t   out_row;
    logic              last_of_run;

    modport source (output valid, output red, output green, output blue,
                    output out_column, output out_row, output last_of_run,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input out_column, input out_row, input last_of_run,
                    output ready);

endinterface

`default_nettype wire

[hdl/bayer_demosaic_2x2.sv]
// Streaming 2x2 Bayer demosaic built around a one-line sample memory.
`default_nettype none

// Raw samples enter in raster order and each sample at (x,y) with x and y both
// nonzero closes the 2x2 window whose top-left corner is (x-1,y-1). The block
// takes one sample per clock unless stalled: the line memory is read at the
// sample's column when it is accepted and written back with the new sample
// when the window stage advances, so a read and a write in the same cycle
// always address different columns. A sample in the last column or the last
// row gives two results, and the last sample of the frame gives four; the
// output register sends one result per cycle while the output is ready. The
// extra results of the last column and of the frame's last sample overlap the
// samples of column 0 and row 0, which give none, so with the output always
// ready only a sample in the last row delays the input. Samples in row 0 or
// column 0 give no result. Writing the width or height restarts the frame at
// (0,0); write configuration only while the block is idle. The line memory
// needs no clearing after reset.
module bayer_demosaic_2x2 #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = bdm_pkg::PIXEL_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire bdm_pkg::cfg_index_t   cfg_index,
    input  wire bdm_pkg::cfg_data_t    cfg_wdata,
    bdm_pixel_if.sink                  pix_in,
    bdm_rgb_if.source                  rgb_out
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WB = (XW + 1 > bdm_pkg::CFG_DATA_BITS) ? XW + 1 : bdm_pkg::CFG_DATA_BITS;
    localparam int W_TOP_I = MAX_WIDTH - MAX_WIDTH % 2;
    localparam int W_RESET_I = (bdm_pkg::RESET_WIDTH < W_TOP_I) ? bdm_pkg::RESET_WIDTH : W_TOP_I;
    localparam logic [WB-1:0] W_TOP = WB'(W_TOP_I);
    localparam logic [WB-1:0] W_MIN = WB'(bdm_pkg::MIN_SIZE);
    localparam logic [bdm_pkg::CFG_DATA_BITS-1:0] H_TOP = bdm_pkg::CFG_DATA_BITS'(bdm_pkg::MAX_HEIGHT);
    localparam logic [bdm_pkg::CFG_DATA_BITS-1:0] H_MIN = bdm_pkg::CFG_DATA_BITS'(bdm_pkg::MIN_SIZE);

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [XW-1:0]         col_t;

    // Configuration, kept as the last column and last row of the frame.
    logic [1:0]      pattern_reg;
    col_t            w_last_reg;
    bdm_pkg::coord_t h_last_reg;
    col_t            w_last_next;
    bdm_pkg::coord_t h_last_next;
    logic [WB-1:0]   w_even;
    logic [WB-1:0]   w_clamped;
    logic [bdm_pkg::CFG_DATA_BITS-1:0] h_even;
    logic [bdm_pkg::CFG_DATA_BITS-1:0] h_clamped;
    logic            restart;

    // Input position.
    col_t            col_count_reg;
    bdm_pkg::coord_t row_count_reg;
    logic            in_accept;

    // Line memory.
    pix_t            line_mem [MAX_WIDTH];
    pix_t            mem_rd_reg;

    // Window stage: the sample whose memory read is in flight.
    logic            s1_valid_reg;
    pix_t            s1_pix_reg;
    col_t            s1_x_reg;
    bdm_pkg::coord_t s1_y_reg;
    logic            s1_emit_reg;
    logic            s1_col_dup_reg;
    logic            s1_row_dup_reg;
    logic            s1_advance;

    // Left neighbors in the current and previous rows.
    pix_t            left_cur_reg;
    pix_t            left_prev_reg;

    // Window selection.
    col_t            ox_full;
    bdm_pkg::coord_t oy;
    logic            rc;
    logic            rr;
    pix_t            sel_r;
    pix_t            sel_b;
    pix_t            sel_ga;
    pix_t            sel_gb;
    logic [PIXEL_BITS:0] g_sum;

    // Output register.
    logic              out_valid_reg;
    bdm_pkg::channel_t red_reg;
    bdm_pkg::channel_t green_reg;
    bdm_pkg::channel_t blue_reg;
    bdm_pkg::coord_t   ox_reg;
    bdm_pkg::coord_t   oy_reg;
    logic              col_dup_reg;
    logic              row_dup_reg;
    logic              phase_c_reg;
    logic              phase_r_reg;
    logic              out_last;
    logic              out_free;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_comb
    begin
        w_even = WB'({cfg_wdata[bdm_pkg::CFG_DATA_BITS-1:1], 1'b0});
        if (w_even < W_MIN)
        begin
            w_clamped = W_MIN;
        end
        else if (w_even > W_TOP)
        begin
            w_clamped = W_TOP;
        end
        else
        begin
            w_clamped = w_even;
        end
        w_last_next = XW'(w_clamped - WB'(1));

        h_even = {cfg_wdata[bdm_pkg::CFG_DATA_BITS-1:1], 1'b0};
        if (h_even < H_MIN)
        begin
            h_clamped = H_MIN;
        end
        else if (h_even > H_TOP)
        begin
            h_clamped = H_TOP;
        end
        else
        begin
            h_clamped = h_even;
        end
        h_last_next = bdm_pkg::COORD_BITS'(h_clamped - bdm_pkg::CFG_DATA_BITS'(1));
    end

    assign restart = cfg_we && (cfg_index == bdm_pkg::CFG_IMAGE_WIDTH ||
                                cfg_index == bdm_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= bdm_pkg::PAT_RGGB;
            w_last_reg  <= XW'(W_RESET_I - 1);
            h_last_reg  <= bdm_pkg::COORD_BITS'(bdm_pkg::RESET_HEIGHT - 1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdm_pkg::CFG_BAYER_PATTERN: pattern_reg <= cfg_wdata[1:0];
                bdm_pkg::CFG_IMAGE_WIDTH:   w_last_reg  <= w_last_next;
                bdm_pkg::CFG_IMAGE_HEIGHT:  h_last_reg  <= h_last_next;
                default:                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input acceptance and position counters
    // ---------------------------------------------------------------
    assign out_last = !(!phase_c_reg && col_dup_reg) && !(!phase_r_reg && row_dup_reg);
    assign out_free = !out_valid_reg || (rgb_out.ready && out_last);
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || out_free);
    assign pix_in.ready = !s1_valid_reg || s1_advance;
    assign in_accept = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (restart)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_count_reg == w_last_reg)
            begin
                col_count_reg <= '0;
                row_count_reg <= (row_count_reg == h_last_reg) ? '0
                                 : row_count_reg + bdm_pkg::COORD_BITS'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg     <= pix_in.raw_pixel[PIXEL_BITS-1:0];
            s1_x_reg       <= col_count_reg;
            s1_y_reg       <= row_count_reg;
            s1_emit_reg    <= (col_count_reg != '0) && (row_count_reg != '0);
            s1_col_dup_reg <= (col_count_reg == w_last_reg);
            s1_row_dup_reg <= (row_count_reg == h_last_reg);
        end
    end

    // ---------------------------------------------------------------
    // Line memory: read at acceptance, written back when the window retires
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mem_rd_reg <= line_mem[col_count_reg];
        end
        if (s1_advance)
        begin
            line_mem[s1_x_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cur_reg  <= '0;
            left_prev_reg <= '0;
        end
        else if (s1_advance)
        begin
            left_cur_reg  <= s1_pix_reg;
            left_prev_reg <= mem_rd_reg;
        end
    end

    // ---------------------------------------------------------------
    // Window: top row is (left_prev, memory), bottom row is (left_cur, sample)
    // ---------------------------------------------------------------
    assign ox_full = s1_x_reg - XW'(1);
    assign oy      = s1_y_reg - bdm_pkg::COORD_BITS'(1);
    assign rc = (pattern_reg == bdm_pkg::PAT_BGGR || pattern_reg == bdm_pkg::PAT_GRBG) ^ ox_full[0];
    assign rr = (pattern_reg == bdm_pkg::PAT_BGGR || pattern_reg == bdm_pkg::PAT_GBRG) ^ oy[0];

    always_comb
    begin
        case ({rr, rc})
            2'b00:
            begin
                sel_r  = left_prev_reg;
                sel_b  = s1_pix_reg;
                sel_ga = mem_rd_reg;
                sel_gb = left_cur_reg;
            end
            2'b01:
            begin
                sel_r  = mem_rd_reg;
                sel_b  = left_cur_reg;
                sel_ga = left_prev_reg;
                sel_gb = s1_pix_reg;
            end
            2'b10:
            begin
                sel_r  = left_cur_reg;
                sel_b  = mem_rd_reg;
                sel_ga = s1_pix_reg;
                sel_gb = left_prev_reg;
            end
            default:
            begin
                sel_r  = s1_pix_reg;
                sel_b  = left_prev_reg;
                sel_ga = left_cur_reg;
                sel_gb = mem_rd_reg;
            end
        endcase
        g_sum = {1'b0, sel_ga} + {1'b0, sel_gb};
    end

    // ---------------------------------------------------------------
    // Output register; the phase bits walk the column and row copies.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_c_reg   <= 1'b0;
            phase_r_reg   <= 1'b0;
        end
        else if (s1_advance && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
            phase_c_reg   <= 1'b0;
            phase_r_reg   <= 1'b0;
        end
        else if (out_valid_reg && rgb_out.ready)
        begin
            if (out_last)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (!phase_c_reg && col_dup_reg)
            begin
                phase_c_reg <= 1'b1;
            end
            else
            begin
                // Move on to the copy in the last row, starting at the left.
                phase_c_reg <= 1'b0;
                phase_r_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit_reg)
        begin
            red_reg     <= bdm_pkg::CHANNEL_BITS'(sel_r);
            green_reg   <= bdm_pkg::CHANNEL_BITS'(g_sum[PIXEL_BITS:1]);
            blue_reg    <= bdm_pkg::CHANNEL_BITS'(sel_b);
            ox_reg      <= bdm_pkg::COORD_BITS'(ox_full);
            oy_reg      <= oy;
            col_dup_reg <= s1_col_dup_reg;
            row_dup_reg <= s1_row_dup_reg;
        end
    end

    assign rgb_out.valid       = out_valid_reg;
    assign rgb_out.red         = red_reg;
    assign rgb_out.green       = green_reg;
    assign rgb_out.blue        = blue_reg;
    assign rgb_out.out_column  = phase_c_reg ? bdm_pkg::COORD_BITS'(w_last_reg) : ox_reg;
    assign rgb_out.out_row     = phase_r_reg ? h_last_reg : oy_reg;
    assign rgb_out.last_of_run = out_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s1_advance) |-> (col_count_reg != s1_x_reg))
        else $error("line memory read and write hit the same column");

    a_column_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= w_last_reg)
        else $error("column counter ran past the last column");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_out.valid && rgb_out.ready && !rgb_out.last_of_run) |=> rgb_out.valid)
        else $error("result run ended before its last result");

    a_stall_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> ($stable(s1_x_reg) && $stable(mem_rd_reg)))
        else $error("window stage changed while stalled");

endmodule

`default_nettype wire

[sim/bayer_demosaic_2x2_tb.sv]
// Self-checking testbench for the streaming 2x2 Bayer demosaic.

import bdm_pkg::*;

typedef struct {
    channel_t   red;
    channel_t   green;
    channel_t   blue;
    coord_t     column;
    coord_t     row;
    logic       last_of_run;
} rgb_pixel_t;

// Mirrors the demosaic state, turns each accepted sample into the RGB pixels
// it should release, and checks the pixels that actually come out.
class demosaic_mirror;

    channel_t    line_memory [MAX_WIDTH_DEFAULT];
    channel_t    left_now;
    channel_t    left_above;
    int unsigned col;
    int unsigned row;
    logic [1:0]  pattern;
    cfg_data_t   width_reg;
    cfg_data_t   height_reg;
    rgb_pixel_t  pending_rgb [$];
    int unsigned mismatches;

    function new();
        foreach (line_memory[i])
            line_memory[i] = '0;
        left_now   = '0;
        left_above = '0;
        col        = 0;
        row        = 0;
        pattern    = PAT_RGGB;
        width_reg  = cfg_data_t'(RESET_WIDTH);
        height_reg = cfg_data_t'(RESET_HEIGHT);
        mismatches = 0;
    endfunction

    function int unsigned frame_width();
        int unsigned w;
        w = {19'd0, width_reg[CFG_DATA_BITS-1:1], 1'b0};
        if (w < MIN_SIZE)
            w = MIN_SIZE;
        if (w > MAX_WIDTH_DEFAULT)
            w = MAX_WIDTH_DEFAULT;
        return w;
    endfunction

    function int unsigned frame_height();
        int unsigned h;
        h = {19'd0, height_reg[CFG_DATA_BITS-1:1], 1'b0};
        if (h < MIN_SIZE)
            h = MIN_SIZE;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function int unsigned samples_to_frame_end();
        return (frame_height() - row) * frame_width() - col;
    endfunction

    function void write_register(cfg_index_t index, cfg_data_t data);
        case (index)
            CFG_BAYER_PATTERN: pattern = data[1:0];
            CFG_IMAGE_WIDTH:
            begin
                width_reg = data;
                col = 0;
                row = 0;
            end
            CFG_IMAGE_HEIGHT:
            begin
                height_reg = data;
                col = 0;
                row = 0;
            end
            default: ;
        endcase
    endfunction

    function void add_pixel(rgb_pixel_t px, int unsigned c, int unsigned r);
        px.column      = coord_t'(c);
        px.row         = coord_t'(r);
        px.last_of_run = 1'b0;
        pending_rgb.push_back(px);
    endfunction

    function void demosaic_sample(channel_t sample);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned last_idx;
        channel_t    win [2][2];
        bit          red_row;
        bit          red_col;
        logic [CHANNEL_BITS:0] green_sum;
        rgb_pixel_t  px;

        w = frame_width();
        h = frame_height();
        x = col;
        y = row;
        win[0][0] = left_above;
        win[0][1] = line_memory[x];
        win[1][0] = left_now;
        win[1][1] = sample;

        if (x >= 1 && y >= 1)
        begin
            red_col = (pattern == PAT_BGGR || pattern == PAT_GRBG);
            red_row = (pattern == PAT_BGGR || pattern == PAT_GBRG);
            // The color phase flips on odd output columns and rows.
            red_col = red_col ^ 1'(x - 1);
            red_row = red_row ^ 1'(y - 1);
            px.red   = win[red_row][red_col];
            px.blue  = win[!red_row][!red_col];
            green_sum = {1'b0, win[red_row][!red_col]} + {1'b0, win[!red_row][red_col]};
            px.green = green_sum[CHANNEL_BITS:1];

            add_pixel(px, x - 1, y - 1);
            if (x == w - 1)
                add_pixel(px, w - 1, y - 1);
            if (y == h - 1)
            begin
                add_pixel(px, x - 1, h - 1);
                if (x == w - 1)
                    add_pixel(px, w - 1, h - 1);
            end
            last_idx = pending_rgb.size() - 1;
            pending_rgb[last_idx].last_of_run = 1'b1;
        end

        left_above     = win[0][1];
        left_now       = sample;
        line_memory[x] = sample;
        if (x + 1 >= w)
        begin
            col = 0;
            row = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col = x + 1;
        end
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task check_field(string name, logic [31:0] seen, logic [31:0] want,
                     coord_t c, coord_t r);
        if (seen !== want)
            report_mismatch($sformatf("%s at (%0d,%0d): got %0h, expected %0h",
                                      name, c, r, seen, want));
    endtask

    task match_pixel(rgb_pixel_t seen);
        rgb_pixel_t want;
        if (pending_rgb.size() == 0)
        begin
            report_mismatch($sformatf("pixel (%0d,%0d) arrived with none pending",
                                      seen.column, seen.row));
            return;
        end
        want = pending_rgb.pop_front();
        check_field("out_column", 32'(seen.column), 32'(want.column), want.column, want.row);
        check_field("out_row", 32'(seen.row), 32'(want.row), want.column, want.row);
        check_field("red", 32'(seen.red), 32'(want.red), want.column, want.row);
        check_field("green", 32'(seen.green), 32'(want.green), want.column, want.row);
        check_field("blue", 32'(seen.blue), 32'(want.blue), want.column, want.row);
        check_field("last_of_run", 32'(seen.last_of_run), 32'(want.last_of_run),
                    want.column, want.row);
    endtask

endclass

module bayer_demosaic_2x2_tb;

    localparam cfg_index_t  CFG_SPARE_INDEX = 2'd3;
    localparam int unsigned RANDOM_SAMPLES  = 300;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned RUN_CAP         = 40;
    localparam int unsigned TIMEOUT_UNITS   = 4000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    cfg_data_t   cfg_wdata;
    bit          no_idle;
    int unsigned hold_requests;

    demosaic_mirror mirror = new();

    // Extremes of the sample range and green sums that reach the carry bit.
    channel_t corner_frame [16] = '{
        16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFE,
        16'h0000, 16'h0000, 16'h5555, 16'hAAAA,
        16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF
    };

    bdm_pixel_if pix_bus ();
    bdm_rgb_if   rgb_bus ();

    bayer_demosaic_2x2 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_bus),
        .rgb_out   (rgb_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_UNITS;
        $display("bayer_demosaic_2x2_tb: FAIL");
        $finish;
    end

    // Output side: random back-pressure, plus a long hold-off on request.
    initial
    begin : rgb_receiver
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left     = 0;
        holds_served  = 0;
        rgb_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                rgb_bus.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                rgb_bus.ready = no_idle || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge clk)
    begin : rgb_monitor
        rgb_pixel_t seen;
        if (rst_n === 1'b1 && rgb_bus.valid === 1'b1 && rgb_bus.ready === 1'b1)
        begin
            seen.red         = rgb_bus.red;
            seen.green       = rgb_bus.green;
            seen.blue        = rgb_bus.blue;
            seen.column      = rgb_bus.out_column;
            seen.row         = rgb_bus.out_row;
            seen.last_of_run = rgb_bus.last_of_run;
            mirror.match_pixel(seen);
        end
    end

    // Valid stays high after an accepted request; the next call either keeps
    // it high with new data or opens a gap.
    task automatic send_sample(channel_t sample);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            pix_bus.valid = 1'b0;
            @(negedge clk);
        end
        pix_bus.valid     = 1'b1;
        pix_bus.raw_pixel = sample;
        do
            @(posedge clk);
        while (pix_bus.ready !== 1'b1);
        mirror.demosaic_sample(sample);
    endtask

    task automatic send_run(int unsigned count);
        repeat (count) send_sample(channel_t'($urandom_range(65535)));
    endtask

    // Waits for every pending pixel, then for the pipeline to empty out.
    task automatic settle_block();
        @(negedge clk);
        pix_bus.valid = 1'b0;
        while (mirror.pending_rgb.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(cfg_index_t index, cfg_data_t data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = data;
        @(posedge clk);
        mirror.write_register(index, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned random_samples;
        int unsigned run_len;
        int unsigned phase;
        cfg_data_t   size_value;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_BAYER_PATTERN;
        cfg_wdata         = '0;
        pix_bus.valid     = 1'b0;
        pix_bus.raw_pixel = '0;
        no_idle           = 1'b0;
        hold_requests     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes: a short run in the first row gives no pixels.
        send_run(6);
        settle_block();

        no_idle = 1'b1;
        program_register(CFG_IMAGE_WIDTH, 13'd4);
        program_register(CFG_IMAGE_HEIGHT, 13'd4);
        program_register(CFG_BAYER_PATTERN, cfg_data_t'(PAT_RGGB));
        foreach (corner_frame[i])
            send_sample(corner_frame[i]);
        settle_block();
        program_register(CFG_SPARE_INDEX, 13'h1FFF);
        // The frame wraps to (0,0); a color order change lands mid-frame.
        send_run(6);
        settle_block();
        program_register(CFG_BAYER_PATTERN, cfg_data_t'(PAT_BGGR));
        send_run(mirror.samples_to_frame_end());
        settle_block();
        no_idle = 1'b0;

        // Odd width rounds down then clamps up; the height clamps to its top.
        program_register(CFG_IMAGE_WIDTH, 13'd3);
        program_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
        program_register(CFG_BAYER_PATTERN, cfg_data_t'(PAT_GRBG));
        send_run(24);

        random_samples = 0;
        phase          = 0;
        while (random_samples < RANDOM_SAMPLES)
        begin
            settle_block();
            if (phase == 0)
            begin
                program_register(CFG_IMAGE_WIDTH, 13'd4);
                program_register(CFG_IMAGE_HEIGHT, 13'd8);
                program_register(CFG_BAYER_PATTERN, cfg_data_t'(PAT_GBRG));
                hold_requests++;
                run_len = mirror.samples_to_frame_end();
            end
            else
            begin
                if ($urandom_range(2) == 0)
                    program_register(CFG_BAYER_PATTERN, cfg_data_t'($urandom_range(3)));
                if ($urandom_range(2) == 0)
                begin
                    size_value = ($urandom_range(7) == 0) ? cfg_data_t'($urandom_range(8191))
                                                          : cfg_data_t'($urandom_range(12));
                    program_register(CFG_IMAGE_WIDTH, size_value);
                end
                if ($urandom_range(2) == 0)
                begin
                    size_value = ($urandom_range(7) == 0) ? cfg_data_t'($urandom_range(8191))
                                                          : cfg_data_t'($urandom_range(10));
                    program_register(CFG_IMAGE_HEIGHT, size_value);
                end
                if ($urandom_range(3) != 0)
                    run_len = mirror.samples_to_frame_end();
                else
                    run_len = $urandom_range(30, 1);
                if (run_len > RUN_CAP)
                    run_len = RUN_CAP;
            end
            no_idle = (phase == 4);
            send_run(run_len);
            random_samples += run_len;
            phase++;
        end
        no_idle = 1'b0;

        settle_block();
        repeat (16) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("bayer_demosaic_2x2_tb: PASS");
        else
            $display("bayer_demosaic_2x2_tb: FAIL");
        $finish;
    end

endmodule
